@@ design/direct_mapped_hash_table_core_assert.svh @@
// Assertion macros shared by the hash table modules.
`ifndef DIRECT_MAPPED_HASH_TABLE_CORE_ASSERT_SVH
`define DIRECT_MAPPED_HASH_TABLE_CORE_ASSERT_SVH
`ifndef SYNTH
// Checks a condition at every clock edge outside reset.
`define DMHT_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("hash table check failed");
// Checks that a trigger is followed by a condition in the next clock cycle.
`define DMHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash table check failed");
`else
`define DMHT_ASSERT(label, cond)
`define DMHT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/dmht_pkg.sv @@
// Types and constants shared by the direct-mapped hash table modules.
package dmht_pkg;

    localparam int TABLE_DEPTH      = 16;
    localparam int SLOT_W           = $clog2(TABLE_DEPTH);
    localparam int SIZE_W           = SLOT_W + 1;
    localparam int CNT_W            = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W            = 5;
    localparam int TABLE_SIZE_RESET = 10;
    localparam int KEY_W            = 31;
    localparam int VALUE_W          = 32;
    localparam int STATUS_W         = 3;
    localparam int SLOT_FIELD_W     = 4;
    localparam int COUNT_FIELD_W    = 5;
    localparam int STEP_W           = $clog2(KEY_W);
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_COLLISION = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [1:0]
    {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    typedef struct packed
    {
        op_t                       op;
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed
    {
        status_t                  status;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [COUNT_FIELD_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed
    {
        op_t                       op;
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
        logic [SLOT_W-1:0]         slot;
    } job_t;

endpackage

@@ design/dmht_front.sv @@
// Front end: takes a request and works out its slot with a bit-serial modulo.
`include "direct_mapped_hash_table_core_assert.svh"

module dmht_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  dmht_pkg::req_t             req,
    input  logic [dmht_pkg::SIZE_W-1:0] divisor,
    output logic                       push,
    output dmht_pkg::job_t             push_job,
    input  logic                       full
);

    dmht_pkg::front_state_t            state_reg, state_next;
    dmht_pkg::req_t                    req_reg, req_next;
    logic [dmht_pkg::KEY_W-1:0]        shift_reg, shift_next;
    logic [dmht_pkg::SLOT_W-1:0]       rem_reg, rem_next;
    logic [dmht_pkg::STEP_W-1:0]       step_reg, step_next;
    logic [dmht_pkg::SIZE_W-1:0]       divisor_reg, divisor_next;
    logic [dmht_pkg::SIZE_W-1:0]       trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmht_pkg::FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        shift_reg   <= shift_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        divisor_reg <= divisor_next;
    end

    // One restoring-division step: bring down the next key bit and subtract if it fits.
    assign trial = {rem_reg, shift_reg[dmht_pkg::KEY_W-1]};

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        divisor_next = divisor_reg;
        req_ready    = 1'b0;
        push         = 1'b0;
        case (state_reg)
            dmht_pkg::FR_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next     = req;
                    shift_next   = req.key;
                    rem_next     = '0;
                    step_next    = '0;
                    divisor_next = divisor;
                    state_next   = dmht_pkg::FR_DIV;
                end
            end
            dmht_pkg::FR_DIV:
            begin
                if (trial >= divisor_reg)
                begin
                    rem_next = dmht_pkg::SLOT_W'(trial - divisor_reg);
                end
                else
                begin
                    rem_next = dmht_pkg::SLOT_W'(trial);
                end
                shift_next = shift_reg << 1;
                step_next  = step_reg + 1'b1;
                if (step_reg == dmht_pkg::STEP_W'(dmht_pkg::KEY_W - 1))
                begin
                    state_next = dmht_pkg::FR_PUSH;
                end
            end
            dmht_pkg::FR_PUSH:
            begin
                push = !full;
                if (!full)
                begin
                    state_next = dmht_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = dmht_pkg::FR_IDLE;
            end
        endcase
    end

    assign push_job.op    = req_reg.op;
    assign push_job.key   = req_reg.key;
    assign push_job.value = req_reg.value;
    assign push_job.slot  = rem_reg;

    `DMHT_ASSERT(a_rem_below_divisor, (state_reg == dmht_pkg::FR_IDLE) || (dmht_pkg::SIZE_W'(rem_reg) < divisor_reg))
    `DMHT_ASSERT(a_divisor_nonzero, (state_reg == dmht_pkg::FR_IDLE) || (divisor_reg != '0))
    `DMHT_ASSERT(a_push_only_with_room, !(push && full))

endmodule

@@ design/dmht_queue.sv @@
// Two-entry queue that carries hashed jobs from the front end to the table.
`include "direct_mapped_hash_table_core_assert.svh"

module dmht_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dmht_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output dmht_pkg::job_t pop_job,
    output logic           avail
);

    dmht_pkg::job_t                entry_reg [dmht_pkg::QUEUE_DEPTH];
    logic [dmht_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [dmht_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [dmht_pkg::QCNT_W-1:0]   count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == dmht_pkg::QPTR_W'(dmht_pkg::QUEUE_DEPTH - 1))
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (pop)
        begin
            if (rd_ptr_reg == dmht_pkg::QPTR_W'(dmht_pkg::QUEUE_DEPTH - 1))
            begin
                rd_ptr_next = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign full    = (count_reg == dmht_pkg::QCNT_W'(dmht_pkg::QUEUE_DEPTH));
    assign avail   = (count_reg != '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    `DMHT_ASSERT(a_no_overflow, !(push && full))
    `DMHT_ASSERT(a_no_underflow, !(pop && !avail))
    `DMHT_ASSERT(a_count_in_range, count_reg <= dmht_pkg::QCNT_W'(dmht_pkg::QUEUE_DEPTH))

endmodule

@@ design/dmht_back.sv @@
// Back end: the slot store, the entry count and the result register.
`include "direct_mapped_hash_table_core_assert.svh"

module dmht_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_avail,
    input  dmht_pkg::job_t job,
    output logic           job_pop,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output dmht_pkg::rsp_t rsp
);

    logic [dmht_pkg::TABLE_DEPTH-1:0]  slot_valid_reg, slot_valid_next;
    logic [dmht_pkg::KEY_W-1:0]        slot_key_reg   [dmht_pkg::TABLE_DEPTH];
    logic signed [dmht_pkg::VALUE_W-1:0] slot_value_reg [dmht_pkg::TABLE_DEPTH];
    logic [dmht_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                              rsp_valid_reg, rsp_valid_next;
    dmht_pkg::rsp_t                    rsp_reg, rsp_next;
    logic                              hit_valid;
    logic                              key_match;
    logic                              wr_key;
    logic                              wr_value;
    dmht_pkg::status_t                 status;

    assign job_pop   = job_avail && (!rsp_valid_reg || rsp_ready);
    assign hit_valid = slot_valid_reg[job.slot];
    assign key_match = (slot_key_reg[job.slot] == job.key);

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        count_next      = count_reg;
        wr_key          = 1'b0;
        wr_value        = 1'b0;
        status          = dmht_pkg::ST_NOT_FOUND;
        case (job.op)
            dmht_pkg::OP_INSERT:
            begin
                if (!hit_valid)
                begin
                    status   = dmht_pkg::ST_INSERTED;
                    wr_key   = job_pop;
                    wr_value = job_pop;
                    if (job_pop)
                    begin
                        slot_valid_next[job.slot] = 1'b1;
                        count_next                = count_reg + 1'b1;
                    end
                end
                else if (key_match)
                begin
                    status   = dmht_pkg::ST_UPDATED;
                    wr_value = job_pop;
                end
                else
                begin
                    status = dmht_pkg::ST_COLLISION;
                end
            end
            dmht_pkg::OP_REMOVE:
            begin
                if (hit_valid && key_match)
                begin
                    status = dmht_pkg::ST_REMOVED;
                    if (job_pop)
                    begin
                        slot_valid_next[job.slot] = 1'b0;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                status = dmht_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (job_pop)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.status      = status;
            rsp_next.slot        = dmht_pkg::SLOT_FIELD_W'(job.slot);
            rsp_next.entry_count = dmht_pkg::COUNT_FIELD_W'(count_next);
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            count_reg      <= count_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (wr_key)
        begin
            slot_key_reg[job.slot] <= job.key;
        end
        if (wr_value)
        begin
            slot_value_reg[job.slot] <= job.value;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `DMHT_ASSERT(a_count_matches_valid, $countones(slot_valid_reg) == int'(count_reg))
    `DMHT_ASSERT_NEXT(a_pop_fills_result, job_pop, rsp_valid_reg)
    `DMHT_ASSERT_NEXT(a_count_moves_on_pop, !job_pop, $stable(count_reg) && $stable(slot_valid_reg))

endmodule

@@ design/direct_mapped_hash_table_core.sv @@
// Top level of the direct-mapped hash table: configuration register and the three stages.
//
// A direct-mapped key/value table with sixteen slots and no collision resolution. Each
// request carries an operation (insert or remove), a 31-bit key and a 32-bit value; the
// key maps to slot = key mod table_size, where table_size comes from the configuration
// port (reset value 10, zero acts as one, anything above sixteen acts as sixteen). An
// insert fills an empty slot or updates the value when the stored key matches, and
// reports a collision otherwise; a remove clears the slot only when its key matches and
// reports not found otherwise. Every request produces exactly one result with a status,
// the slot and the number of occupied slots after the operation. The slot is found by a
// bit-serial restoring modulo that takes one key bit per clock, so the front end accepts a
// request, runs the modulo over the 31 key bits and then hands the job to a two-entry
// queue, waiting there while the queue is full; it takes a new request only once the last
// job has been handed on. The back end pops a job once its result register can take the
// result and updates the table, and the queue plus the output register let the front end
// keep working while a result waits to be taken. The valid bits are cleared at reset, so
// the table is ready at once with no clearing pass. Write the table size only while no
// request is in flight; it is sampled when a request is accepted.

module direct_mapped_hash_table_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  dmht_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output dmht_pkg::rsp_t             rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dmht_pkg::CFG_W-1:0] cfg_data
);

    logic [dmht_pkg::CFG_W-1:0]  table_size_reg, table_size_next;
    logic [dmht_pkg::SIZE_W-1:0] divisor;
    logic                        push;
    dmht_pkg::job_t              push_job;
    logic                        full;
    logic                        pop;
    dmht_pkg::job_t              pop_job;
    logic                        avail;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        table_size_next = table_size_reg;
        if (cfg_valid)
        begin
            table_size_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= dmht_pkg::CFG_W'(dmht_pkg::TABLE_SIZE_RESET);
        end
        else
        begin
            table_size_reg <= table_size_next;
        end
    end

    // Clamp the configured size into the range the table can serve.
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            divisor = dmht_pkg::SIZE_W'(1);
        end
        else if (int'(table_size_reg) > dmht_pkg::TABLE_DEPTH)
        begin
            divisor = dmht_pkg::SIZE_W'(dmht_pkg::TABLE_DEPTH);
        end
        else
        begin
            divisor = dmht_pkg::SIZE_W'(table_size_reg);
        end
    end

    // The front end hashes one request at a time.
    dmht_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .divisor   (divisor),
        .push      (push),
        .push_job  (push_job),
        .full      (full)
    );

    // The queue decouples hashing from the table update.
    dmht_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .avail    (avail)
    );

    // The back end owns the store and the result register.
    dmht_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (avail),
        .job       (pop_job),
        .job_pop   (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
